// ===== rtl/core/ct_pkg.sv =====
// Shared types and constants for the columnar transposition block.
// No dependencies; every other file in rtl/core except ct_ram imports this package.
package ct_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd2;

  localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 4'd5;
  localparam logic [CFG_DATA_W-1:0] ROUNDS_RESET  = 4'd1;
  localparam logic                  DIR_ENCRYPT   = 1'b0;
  localparam logic                  DIR_DECRYPT   = 1'b1;

  // Column range: 1..8, held internally as columns minus one
  localparam int                    NUM_COLUMNS = 8;
  localparam int                    COL_IDX_W   = 3;
  localparam logic [CFG_DATA_W-1:0] MAX_COLUMNS = 4'd8;

  // Byte codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } ct_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
    logic       overflowed;
  } ct_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CALC,
    ST_ROUND_RD,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_HOLD
  } ct_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_input;
    logic calc_clear;
    logic calc_step;
    logic round_start;
    logic round_step;
    logic round_end;
    logic emit_start;
    logic emit_load_char;
    logic emit_load_sep;
    logic emit_next;
    logic msg_clear;
  } ct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_taken;
    logic calc_done;
    logic round_end_cell;
    logic last_round;
    logic emit_end_cell;
    logic group_full;
    logic out_taken;
  } ct_status_t;

endpackage

// ===== rtl/core/columnar_transposition_top.sv =====
// Top level of the unkeyed columnar transposition block.
// Depends on ct_pkg, ct_ctrl, ct_datapath (and ct_ram through it).
//
// Message bytes arrive on the item channel, one beat per cycle, until a beat
// with is_last set. Accepted bytes within the grid capacity, spaces too, count
// toward the message length; spaces are not stored. Bytes past the grid
// capacity, floor(GRID_CELLS / columns) * columns, are dropped and every
// result beat of that message then carries overflowed. After the last byte the
// item channel stalls until the final result beat is taken. The row count is
// found by repeated addition, one row per cycle. Each round then walks the
// cells = rows * columns grid once, read from one grid RAM and written to the
// other. Emission reads one byte per RAM access, through a read, a load and a
// hold state until the result is taken; each group separator adds one more
// hold. Encrypt fills row by row with 'x' padding and reads column by column;
// decrypt does the reverse, pads with zero bytes and shows every 'x' as a
// space. A space follows every GROUP_SIZE output bytes, including the final
// group, and last_out marks the final beat. The grid RAMs are never cleared:
// stale cells read in the first round past the stored bytes become padding.
// Configuration (columns 0 acts as 1, above 8 as 8; rounds 0 acts as 1) must
// be written only while idle; the block itself does not enforce this.
module columnar_transposition_top #(
  parameter int GRID_CELLS = 48,
  parameter int GROUP_SIZE = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ct_pkg::ct_in_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ct_pkg::ct_out_t               result
);

  import ct_pkg::*;

  ct_cmd_t    cmd;
  ct_status_t status;

  // Take input beats only while loading a message
  assign item_stall = ~cmd.take_input;

  ct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ct_datapath #(
    .GRID_CELLS (GRID_CELLS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== rtl/core/ct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ct_ctrl.sv =====
// Sequencer for the columnar transposition block: load, row count,
// transposition rounds and grouped emission. Depends on ct_pkg.
module ct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  ct_pkg::ct_status_t status,
  output ct_pkg::ct_cmd_t    cmd
);

  import ct_pkg::*;

  ct_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.take_input = 1'b1;
        cmd.calc_clear = 1'b1;
        if (status.last_taken) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (status.calc_done) begin
          cmd.round_start = 1'b1;
          state_next      = ST_ROUND_RD;
        end else begin
          cmd.calc_step = 1'b1;
        end
      end
      ST_ROUND_RD: begin
        cmd.round_step = 1'b1;
        if (status.round_end_cell) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write of the round lands here; flip grids
        cmd.round_end = 1'b1;
        if (status.last_round) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_RD;
        end else begin
          cmd.round_start = 1'b1;
          state_next      = ST_ROUND_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        cmd.emit_load_char = 1'b1;
        state_next         = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (status.out_taken) begin
          if (status.group_full) begin
            cmd.emit_load_sep = 1'b1;
          end else if (status.emit_end_cell) begin
            cmd.msg_clear = 1'b1;
            state_next    = ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/core/ct_datapath.sv =====
// Datapath: config registers, message counters, two grid RAMs used
// ping-pong, transposition address walker and output register.
// Depends on ct_pkg and ct_ram.
module ct_datapath #(
  parameter int GRID_CELLS = 48,
  parameter int GROUP_SIZE = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ct_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                               item_valid,
  input  ct_pkg::ct_in_t                     item,
  input  logic                               result_stall,
  output logic                               result_valid,
  output ct_pkg::ct_out_t                    result,
  input  ct_pkg::ct_cmd_t                    cmd,
  output ct_pkg::ct_status_t                 status
);

  import ct_pkg::*;

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int CNT_W  = $clog2(GRID_CELLS + 1);
  localparam int GRP_W  = $clog2(GROUP_SIZE + 1);

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] columns;
  logic [CFG_DATA_W-1:0] rounds;
  logic                  direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= COLUMNS_RESET;
      rounds    <= ROUNDS_RESET;
      direction <= DIR_ENCRYPT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:   columns   <= cfg_data;
        CFG_ROUNDS:    rounds    <= cfg_data;
        CFG_DIRECTION: direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [COL_IDX_W-1:0]  col_m1;
  logic [CNT_W-1:0]      col_cnt;
  logic [CFG_DATA_W-1:0] num_rounds;
  logic                  decrypt;

  always_comb begin
    if (columns == '0) begin
      col_m1 = '0;
    end else if (columns > MAX_COLUMNS) begin
      col_m1 = COL_IDX_W'(MAX_COLUMNS - CFG_DATA_W'(1));
    end else begin
      col_m1 = COL_IDX_W'(columns - CFG_DATA_W'(1));
    end
  end

  assign col_cnt    = CNT_W'(col_m1) + CNT_W'(1);
  assign num_rounds = (rounds == '0) ? CFG_DATA_W'(1) : rounds;
  assign decrypt    = (direction == DIR_DECRYPT);

  // Per-column-count row limit and capacity, fixed at elaboration
  logic [CNT_W-1:0] maxrows_tab [NUM_COLUMNS];
  logic [CNT_W-1:0] cap_tab     [NUM_COLUMNS];

  for (genvar k = 0; k < NUM_COLUMNS; k++) begin : g_tab
    localparam int MaxRows = GRID_CELLS / (k + 1);
    localparam int Cap     = MaxRows * (k + 1);
    assign maxrows_tab[k] = CNT_W'(MaxRows);
    assign cap_tab[k]     = CNT_W'(Cap);
  end

  logic [CNT_W-1:0] maxrows;
  logic [CNT_W-1:0] cap;

  assign maxrows = maxrows_tab[col_m1];
  assign cap     = cap_tab[col_m1];

  // ---------------- message load ----------------
  logic [CNT_W-1:0] msg_len;
  logic [CNT_W-1:0] filled;
  logic             ovf;
  logic             accept;
  logic             room;
  logic             store;

  assign accept = item_valid & cmd.take_input;
  assign room   = (msg_len < cap);
  assign store  = accept & room & (item.char_in != CHAR_SPACE)
                  & (filled < CNT_W'(GRID_CELLS));

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      msg_len <= '0;
      filled  <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      if (room) begin
        msg_len <= msg_len + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
      if (store) begin
        filled <= filled + CNT_W'(1);
      end
    end
  end

  // ---------------- row count ----------------
  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cells;

  always_ff @(posedge clk) begin
    if (rst || cmd.calc_clear) begin
      rows  <= '0;
      cells <= '0;
    end else if (cmd.calc_step) begin
      rows  <= rows + CNT_W'(1);
      cells <= cells + col_cnt;
    end
  end

  // ---------------- transposition rounds ----------------
  logic [ADDR_W-1:0]     p;
  logic [ADDR_W-1:0]     inner;
  logic [ADDR_W-1:0]     outer;
  logic [ADDR_W-1:0]     dst;
  logic [CFG_DATA_W-1:0] rd_cnt;
  logic                  src_sel;   // 0: read grid A, write grid B
  logic                  wr_v;
  logic [ADDR_W-1:0]     wr_dst;
  logic                  wr_pad;

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] stride;
  logic [CNT_W:0]   dst_sum;
  logic             inner_wrap;

  assign lim        = decrypt ? rows : col_cnt;
  assign stride     = decrypt ? col_cnt : rows;
  assign dst_sum    = (CNT_W + 1)'(dst) + (CNT_W + 1)'(stride);
  assign inner_wrap = (CNT_W'(inner) == lim - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      p     <= '0;
      inner <= '0;
      outer <= '0;
      dst   <= '0;
    end else if (cmd.round_step) begin
      p <= p + ADDR_W'(1);
      if (inner_wrap) begin
        inner <= '0;
        outer <= outer + ADDR_W'(1);
        dst   <= outer + ADDR_W'(1);
      end else begin
        inner <= inner + ADDR_W'(1);
        dst   <= dst_sum[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.calc_clear) begin
      src_sel <= 1'b0;
      rd_cnt  <= '0;
    end else if (cmd.round_end) begin
      src_sel <= ~src_sel;
      rd_cnt  <= rd_cnt + CFG_DATA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_v <= 1'b0;
    end else begin
      wr_v <= cmd.round_step;
    end
    wr_dst <= dst;
    wr_pad <= (rd_cnt == '0) && (CNT_W'(p) >= filled);
  end

  // ---------------- grid memories ----------------
  logic [ADDR_W-1:0] emit_p;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;
  logic [7:0]        src_data;
  logic [7:0]        round_val;
  logic [7:0]        pad_val;
  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] waddr_a;
  logic [7:0]        wdata_a;

  assign raddr    = cmd.round_step ? p : emit_p;
  assign src_data = src_sel ? rdata_b : rdata_a;
  assign pad_val  = decrypt ? CHAR_NUL : CHAR_X;

  always_comb begin
    round_val = wr_pad ? pad_val : src_data;
    if (!decrypt && round_val == CHAR_NUL) begin
      round_val = CHAR_X;
    end
  end

  assign we_a    = store | (wr_v & src_sel);
  assign waddr_a = store ? ADDR_W'(filled) : wr_dst;
  assign wdata_a = store ? item.char_in : round_val;
  assign we_b    = wr_v & ~src_sel;

  ct_ram #(
    .WIDTH (8),
    .DEPTH (GRID_CELLS)
  ) u_grid_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  ct_ram #(
    .WIDTH (8),
    .DEPTH (GRID_CELLS)
  ) u_grid_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_dst),
    .wdata (round_val),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // ---------------- emission ----------------
  logic [GRP_W-1:0] grp;
  logic [GRP_W-1:0] grp_inc;
  logic             emit_end;
  logic             out_taken;

  assign grp_inc   = grp + GRP_W'(1);
  assign emit_end  = (CNT_W'(emit_p) == cells - CNT_W'(1));
  assign out_taken = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_p <= '0;
      grp    <= '0;
    end else begin
      if (cmd.emit_load_char) begin
        grp <= grp_inc;
      end else if (cmd.emit_load_sep) begin
        grp <= '0;
      end
      if (cmd.emit_next) begin
        emit_p <= emit_p + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load_char || cmd.emit_load_sep) begin
      result_valid <= 1'b1;
    end else if (out_taken) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load_char) begin
      result.char_out   <= (decrypt && src_data == CHAR_X) ? CHAR_SPACE : src_data;
      result.last_out   <= emit_end && (grp_inc != GRP_W'(GROUP_SIZE));
      result.overflowed <= ovf;
    end else if (cmd.emit_load_sep) begin
      result.char_out   <= CHAR_SPACE;
      result.last_out   <= emit_end;
      result.overflowed <= ovf;
    end
  end

  // ---------------- status ----------------
  assign status.last_taken     = accept & item.is_last;
  assign status.calc_done      = (cells >= msg_len) || (rows == maxrows);
  assign status.round_end_cell = (CNT_W'(p) == cells - CNT_W'(1));
  assign status.last_round     = (rd_cnt == num_rounds - CFG_DATA_W'(1));
  assign status.emit_end_cell  = emit_end;
  assign status.group_full     = (grp == GRP_W'(GROUP_SIZE));
  assign status.out_taken      = out_taken;

endmodule

// ===== rtl/core/ct_checker.sv =====
// Port-level checks for columnar_transposition_top, attached by bind.
// Depends on ct_pkg.
module ct_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input ct_pkg::ct_in_t  item,
  input logic            result_valid,
  input logic            result_stall,
  input ct_pkg::ct_out_t result
);

  import ct_pkg::*;

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // Input and output never move in the same phase
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item taken while a result beat is pending");

  // A last item ends loading
  a_last_item_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.is_last) |=> item_stall)
    else $error("input not stalled after the last byte");

  // Taking the final beat ends the message
  a_last_beat_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.last_out) |=> !result_valid)
    else $error("result beat follows the final beat");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

endmodule

bind columnar_transposition_top ct_checker u_ct_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
